[rtl/qss_pkg.sv]
package qss_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_SEND       = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_INVALIDATE = 2'd3
  } op_e;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    op_e         op;
    logic [5:0]  slot_index;
    logic [31:0] msg_size;
    logic [1:0]  priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  found_slot;
    logic [63:0] prio_bytes;
    logic [31:0] prio_messages;
    logic [63:0] total_bytes;
    logic [31:0] total_messages;
  } res_t;

  // one counter pair: a priority lane or the slot totals
  typedef struct packed {
    logic [63:0] bytes;
    logic [31:0] msgs;
  } cnt_t;

endpackage

[rtl/qss_ram.sv]
module qss_ram #(
  parameter int WIDTH = 480,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/queue_stats_slot_table.sv]
// Queue statistics slot table.
// Command channel: req_i is taken at a rising edge with start high and busy
// low. Ops: allocate the lowest free slot, count a sent message, clear a
// slot's counters, invalidate a slot.
// Result channel: res_o is shown for one cycle with res_valid_o high; both are
// registered from the update state ST_EXEC that an accepted item enters. The
// receiver cannot stall; every item gives exactly one result.
// A new item is not taken while busy. busy is high for the cycle in which
// the slot's counter row, read from the registered-read RAM, is updated
// and written back; a new item may be taken while the last result is shown.
// Each slot owns one RAM row holding all its priority lanes and its totals.
// Config: cfg_data_i sets slots_in_use, written with cfg_valid_i high, always
// taken; unchecked, the user must write it only while no item is in flight.
// Reset: all slots invalid, slots_in_use = 64. The RAM needs no clearing:
// a slot's row is zeroed on allocate and its contents unused while it is free.
module queue_stats_slot_table #(
  parameter int NUM_SLOTS      = 64,
  parameter int NUM_PRIORITIES = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  qss_pkg::req_t req_i,
  output logic          res_valid_o,
  output qss_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [6:0]    cfg_data_i
);

  localparam int SW   = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
  localparam int PW   = NUM_PRIORITIES > 1 ? $clog2(NUM_PRIORITIES) : 1;
  localparam int LW   = $clog2(NUM_PRIORITIES + 1);
  localparam int ROWW = (NUM_PRIORITIES + 1) * $bits(qss_pkg::cnt_t);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  typedef qss_pkg::cnt_t [NUM_PRIORITIES:0] row_t;

  state_e                 state_q, state_d;
  logic [6:0]             slots_in_use_q;
  logic [NUM_SLOTS-1:0]   valid_q;
  qss_pkg::op_e           op_q;
  logic                   ok_q, in_range_q;
  logic [SW-1:0]          slot_q;
  logic [PW-1:0]          lane_q;
  logic [31:0]            size_q;
  qss_pkg::res_t          res_q, res_d;
  logic                   res_valid_q;

  logic                   accept;
  logic [NUM_SLOTS-1:0]   free_v, low_v;
  logic [SW-1:0]          free_idx, tgt_slot;
  logic                   any_free, in_range, ok_d;
  logic [PW-1:0]          lane_d;
  logic [LW-1:0]          lane_ix;
  logic                   ram_we;
  logic [ROWW-1:0]        ram_rdata, ram_wdata;
  row_t                   row_rd, row_upd;
  logic                   alloc_ok, send_ok, clear_ok, inval_ok;

  assign accept      = start && (state_q == ST_IDLE);
  assign busy        = (state_q == ST_EXEC);
  assign cfg_ready_o = 1'b1;

  // lowest free slot: isolate the lowest set bit, then encode it
  assign free_v   = ~valid_q;
  assign low_v    = free_v & (~free_v + NUM_SLOTS'(1));
  assign any_free = |free_v;

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      free_idx = free_idx | (low_v[i] ? SW'(i) : SW'(0));
    end
  end

  assign in_range = (32'(req_i.slot_index) < 32'(slots_in_use_q)) &&
                    (32'(req_i.slot_index) < 32'(NUM_SLOTS));

  assign lane_d = (32'(req_i.priority_req) >= 32'(NUM_PRIORITIES)) ?
                  PW'(NUM_PRIORITIES - 1) : PW'(req_i.priority_req);

  always_comb begin
    tgt_slot = SW'(req_i.slot_index);
    ok_d     = 1'b0;
    case (req_i.op)
      qss_pkg::OP_ALLOC: begin
        tgt_slot = free_idx;
        ok_d     = any_free && (32'(free_idx) < 32'(slots_in_use_q));
      end
      qss_pkg::OP_SEND:       ok_d = in_range && valid_q[tgt_slot];
      qss_pkg::OP_CLEAR:      ok_d = in_range;
      qss_pkg::OP_INVALIDATE: ok_d = in_range && valid_q[tgt_slot];
      default:                ok_d = 1'b0;
    endcase
  end

  assign alloc_ok = busy && (op_q == qss_pkg::OP_ALLOC) && ok_q;
  assign send_ok  = busy && (op_q == qss_pkg::OP_SEND) && ok_q;
  assign clear_ok = busy && (op_q == qss_pkg::OP_CLEAR) && ok_q;
  assign inval_ok = busy && (op_q == qss_pkg::OP_INVALIDATE) && ok_q;
  assign ram_we   = alloc_ok || send_ok || clear_ok || inval_ok;

  assign row_rd  = row_t'(ram_rdata);
  assign lane_ix = LW'(lane_q);

  always_comb begin
    row_upd = row_rd;
    row_upd[lane_ix].bytes = row_rd[lane_ix].bytes + 64'(size_q);
    row_upd[lane_ix].msgs  = row_rd[lane_ix].msgs + 32'd1;
    row_upd[NUM_PRIORITIES].bytes = row_rd[NUM_PRIORITIES].bytes + 64'(size_q);
    row_upd[NUM_PRIORITIES].msgs  = row_rd[NUM_PRIORITIES].msgs + 32'd1;
  end

  // everything but a send writes a zero row
  assign ram_wdata = send_ok ? ROWW'(row_upd) : '0;

  qss_ram #(
    .WIDTH (ROWW),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (tgt_slot),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    res_d = '0;
    case (op_q)
      qss_pkg::OP_ALLOC: begin
        res_d.status     = ok_q ? qss_pkg::STATUS_OK : qss_pkg::STATUS_FULL;
        res_d.found_slot = ok_q ? 6'(slot_q) : 6'd0;
      end
      qss_pkg::OP_SEND: begin
        res_d.status = ok_q ? qss_pkg::STATUS_OK : qss_pkg::STATUS_INVALID;
        if (ok_q) begin
          res_d.prio_bytes     = row_upd[lane_ix].bytes;
          res_d.prio_messages  = row_upd[lane_ix].msgs;
          res_d.total_bytes    = row_upd[NUM_PRIORITIES].bytes;
          res_d.total_messages = row_upd[NUM_PRIORITIES].msgs;
        end
      end
      qss_pkg::OP_CLEAR, qss_pkg::OP_INVALIDATE: begin
        res_d.status = in_range_q ? qss_pkg::STATUS_OK : qss_pkg::STATUS_INVALID;
      end
      default: res_d = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      slots_in_use_q <= 7'd64;
      valid_q        <= '0;
      res_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= busy;
      if (cfg_valid_i && cfg_ready_o) begin
        slots_in_use_q <= cfg_data_i;
      end
      if (alloc_ok) begin
        valid_q[slot_q] <= 1'b1;
      end else if (inval_ok) begin
        valid_q[slot_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= req_i.op;
      ok_q       <= ok_d;
      in_range_q <= in_range;
      slot_q     <= tgt_slot;
      lane_q     <= lane_d;
      size_q     <= req_i.msg_size;
    end
    if (busy) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // the RAM row is only written back in the update cycle
  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_EXEC))
    else $error("counter row written outside the update cycle");

  // busy falls again after each item's update cycle
  a_one_exec_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("update cycle longer than one clock");

  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == ST_EXEC))
    else $error("result shown without a preceding update cycle");

  a_alloc_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && $past(alloc_ok)) |-> valid_q[$past(slot_q)])
    else $error("allocated slot not marked valid");

endmodule

[verif/queue_stats_mirror_pkg.sv]
package queue_stats_mirror_pkg;
  import qss_pkg::*;

  localparam int SLOTS = 64;
  localparam int PRIOS = 4;

  // Mirror of the slot table: predicts each result and checks the results in order.
  class queue_stats_mirror;
    logic [6:0]  slots_in_use;
    bit          slot_live [SLOTS];
    logic [63:0] lane_bytes [SLOTS][PRIOS];
    logic [31:0] lane_msgs [SLOTS][PRIOS];
    logic [63:0] sum_bytes [SLOTS];
    logic [31:0] sum_msgs [SLOTS];
    res_t        pending_results [$];
    int          failures;

    function new();
      slots_in_use = 7'd64;
      failures = 0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_live[s] = 1'b0;
        clear_slot(s);
      end
    endfunction

    function int active();
      return (slots_in_use > SLOTS) ? SLOTS : int'(slots_in_use);
    endfunction

    function void set_count(logic [6:0] v);
      slots_in_use = v;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void clear_slot(int s);
      for (int p = 0; p < PRIOS; p++) begin
        lane_bytes[s][p] = '0;
        lane_msgs[s][p]  = '0;
      end
      sum_bytes[s] = '0;
      sum_msgs[s]  = '0;
    endfunction

    function res_t with_counters(res_t r, int s, int p);
      r.prio_bytes     = lane_bytes[s][p];
      r.prio_messages  = lane_msgs[s][p];
      r.total_bytes    = sum_bytes[s];
      r.total_messages = sum_msgs[s];
      return r;
    endfunction

    // Called for every item taken by the block
    function void take_command(req_t c);
      res_t r;
      int   cnt;
      int   s;
      int   p;
      int   k;
      r   = '0;
      cnt = active();
      p   = int'(c.priority_req);
      if (p >= PRIOS) p = PRIOS - 1;
      if (c.op == OP_ALLOC) begin
        k = 0;
        while (k < cnt && slot_live[k]) k++;
        if (k >= cnt) begin
          r.status = STATUS_FULL;
        end else begin
          clear_slot(k);
          slot_live[k] = 1'b1;
          r.found_slot = 6'(k);
          r = with_counters(r, k, p);
        end
      end else begin
        s = int'(c.slot_index);
        if (s >= cnt) begin
          r.status = STATUS_INVALID;
        end else begin
          case (c.op)
            OP_SEND: begin
              if (slot_live[s]) begin
                lane_bytes[s][p] += 64'(c.msg_size);
                lane_msgs[s][p]  += 32'd1;
                sum_bytes[s]     += 64'(c.msg_size);
                sum_msgs[s]      += 32'd1;
              end else begin
                r.status = STATUS_INVALID;
              end
            end
            OP_CLEAR: begin
              clear_slot(s);
            end
            OP_INVALIDATE: begin
              if (slot_live[s]) begin
                slot_live[s] = 1'b0;
                clear_slot(s);
              end
            end
            default: ;
          endcase
          r = with_counters(r, s, p);
        end
      end
      pending_results.push_back(r);
    endfunction

    // Mostly live slots below the count, some free ones, a few out of range
    function int pick_slot();
      int cnt;
      int roll;
      int live [$];
      cnt  = active();
      roll = $urandom_range(0, 99);
      if (cnt == 0 || roll < 10) return $urandom_range(0, SLOTS - 1);
      for (int k = 0; k < cnt; k++) begin
        if (slot_live[k]) live.push_back(k);
      end
      if (roll < 70 && live.size() > 0) return live[$urandom_range(0, live.size() - 1)];
      return $urandom_range(0, cnt - 1);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void match_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: 0x%0h", got);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("found_slot", 64'(want.found_slot), 64'(got.found_slot));
      compare_field("prio_bytes", want.prio_bytes, got.prio_bytes);
      compare_field("prio_messages", 64'(want.prio_messages), 64'(got.prio_messages));
      compare_field("total_bytes", want.total_bytes, got.total_bytes);
      compare_field("total_messages", 64'(want.total_messages), 64'(got.total_messages));
    endfunction
  endclass

endpackage

[verif/tb_top.sv]
module tb_top;
  import qss_pkg::*;
  import queue_stats_mirror_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int GAP_MAX     = 18;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  req_t       cmd;
  logic       res_valid_o;
  res_t       res_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [6:0] cfg_data_i;

  queue_stats_mirror mirror;
  int                quiet = 0;
  int                gap_ceiling;
  logic [6:0]        phase_counts [10];
  int                alloc_pct;
  int                n_items;

  always #4 clk_i = ~clk_i;

  queue_stats_slot_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (cmd),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) mirror.match_result(res_o);
  end

  // ends the run if nothing moves on any channel for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic req_t make_cmd(op_e o, int s, logic [31:0] sz, int p);
    req_t r;
    r.op           = o;
    r.slot_index   = 6'(s);
    r.msg_size     = sz;
    r.priority_req = 2'(p);
    return r;
  endfunction

  // returns just after the edge that took the item
  task automatic issue(req_t r);
    int gap;
    gap = $urandom_range(0, gap_ceiling);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    cmd   <= r;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    mirror.take_command(r);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (mirror.outstanding() > 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_count(logic [6:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    mirror.set_count(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(logic [6:0] count, int items, int pct);
    req_t r;
    int   roll;
    drain();
    write_count(count);
    repeat (items) begin
      roll = $urandom_range(0, 99);
      if (roll < pct) begin
        r.op = OP_ALLOC;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60) r.op = OP_SEND;
        else if (roll < 80) r.op = OP_INVALIDATE;
        else r.op = OP_CLEAR;
      end
      r.slot_index = 6'(mirror.pick_slot());
      case ($urandom_range(0, 3))
        0: r.msg_size = 32'd0;
        1: r.msg_size = 32'hFFFF_FFFF;
        2: r.msg_size = 32'($urandom_range(0, 255));
        default: r.msg_size = $urandom;
      endcase
      r.priority_req = 2'($urandom_range(0, 3));
      // now and then let the table go quiet before the next item
      if ($urandom_range(0, 39) == 0) drain();
      issue(r);
    end
  endtask

  initial begin
    mirror      = new();
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd         = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    gap_ceiling = GAP_MAX;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // slot count as after reset
    issue(make_cmd(OP_ALLOC, 0, $urandom, 2));
    issue(make_cmd(OP_SEND, 0, 32'hFFFF_FFFF, 0));
    issue(make_cmd(OP_SEND, 0, 32'hFFFF_FFFF, 3));
    issue(make_cmd(OP_SEND, 0, 32'd0, 1));
    issue(make_cmd(OP_SEND, 0, $urandom, 2));
    issue(make_cmd(OP_SEND, 5, 32'd100, 1));      // free slot
    issue(make_cmd(OP_CLEAR, 5, 32'd0, 0));
    issue(make_cmd(OP_INVALIDATE, 5, 32'd0, 3));
    issue(make_cmd(OP_CLEAR, 0, 32'd0, 0));
    issue(make_cmd(OP_SEND, 0, 32'hFFFF_FFFF, 3));
    issue(make_cmd(OP_INVALIDATE, 0, 32'd0, 3));
    issue(make_cmd(OP_SEND, 0, 32'd7, 3));
    issue(make_cmd(OP_ALLOC, 63, 32'd0, 3));
    issue(make_cmd(OP_ALLOC, 0, 32'd0, 1));
    issue(make_cmd(OP_SEND, 1, 32'hFFFF_FFFF, 1));

    // zero slot count: table full, every index out of range
    drain();
    write_count(7'd0);
    issue(make_cmd(OP_ALLOC, 0, 32'd0, 0));
    issue(make_cmd(OP_SEND, 0, 32'd1, 0));
    issue(make_cmd(OP_CLEAR, 63, 32'd0, 0));
    issue(make_cmd(OP_INVALIDATE, 0, 32'd0, 0));

    // count lowered to one: slot 1 kept but out of reach
    drain();
    write_count(7'd1);
    issue(make_cmd(OP_ALLOC, 0, 32'd0, 0));
    issue(make_cmd(OP_SEND, 1, 32'd1, 1));
    issue(make_cmd(OP_INVALIDATE, 0, 32'd0, 0));
    issue(make_cmd(OP_ALLOC, 0, 32'd0, 3));

    // count above the built size is capped
    drain();
    write_count(7'd127);
    issue(make_cmd(OP_SEND, 1, 32'd1, 1));
    issue(make_cmd(OP_SEND, 63, 32'd1, 2));

    phase_counts = '{7'd64, 7'd5, 7'd127, 7'd1, 7'd64, 7'd12, 7'd2, 7'd33, 7'd64, 7'd100};
    phase_counts[7] = 7'($urandom_range(1, 127));
    for (int ph = 0; ph < 10; ph++) begin
      gap_ceiling = (ph % 3 == 1) ? 0 : GAP_MAX;
      // first phase fills the whole table
      alloc_pct   = (ph == 0) ? 90 : $urandom_range(10, 50);
      n_items     = (ph == 0) ? 80 : 55;
      run_phase(phase_counts[ph], n_items, alloc_pct);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mirror.failures == 0 && mirror.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
